/* rtl/pafp_pkg.sv */
// Shared types, constants and the square-root step for the focal-point phase block.
`timescale 1ns / 1ps
`default_nettype none

package pafp_pkg;

    // Register map, indexed by paddr[4:2]
    typedef enum logic [2:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_FOCAL_Z   = 3'd2,
        REG_INV_WAVE  = 3'd3,
        REG_TWIN_TRAP = 3'd4
    } t_reg_idx;

    localparam int REG_IDX_LSB = 2;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    // Reset values of the configuration registers
    localparam logic [23:0] FOCAL_X_RST  = 24'd0;
    localparam logic [23:0] FOCAL_Y_RST  = 24'd0;
    localparam logic [23:0] FOCAL_Z_RST  = 24'd31457;
    localparam logic [23:0] INV_WAVE_RST = 24'd7640000;

    // Queue depths
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    // Square-root pipeline: one result bit per stage
    localparam int SQRT_STEPS = 26;
    localparam int SUM_W      = 50;
    localparam int SQ_W       = 49;
    localparam int ROOT_W     = 52;
    localparam int DIST_W     = 25;
    localparam int PROD_W     = 49;
    localparam int FRAC_W     = 36;
    localparam logic [15:0] HALF_TURN = 16'h8000;

    typedef struct packed {
        logic signed [23:0] focal_x;
        logic signed [23:0] focal_y;
        logic signed [23:0] focal_z;
        logic        [23:0] inv_wave;
        logic               twin_trap;
    } t_cfg;

    // One classified item between front and back
    typedef struct packed {
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic signed [24:0] dz;
        logic               half;
        logic               last;
    } t_job;

    typedef struct packed {
        logic [SUM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_root_st;

    // One digit-by-digit square-root step
    function automatic t_root_st root_step(input t_root_st s, input logic [ROOT_W-1:0] bitv);
        t_root_st          o;
        logic [ROOT_W-1:0] trial;
        trial = s.root + bitv;
        if ({{(ROOT_W-SUM_W){1'b0}}, s.rem} >= trial) begin
            o.rem  = s.rem - trial[SUM_W-1:0];
            o.root = (s.root >> 1) + bitv;
        end else begin
            o.rem  = s.rem;
            o.root = s.root >> 1;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

/* rtl/pafp_cfg.sv */
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module pafp_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pafp_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [pafp_pkg::PDATA_W-1:0]    pwdata,
    output logic      [pafp_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready,
    output pafp_pkg::t_cfg                       o_cfg
);
    import pafp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:REG_IDX_LSB]);
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    // Write the addressed register on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x   <= FOCAL_X_RST;
            r_cfg.focal_y   <= FOCAL_Y_RST;
            r_cfg.focal_z   <= FOCAL_Z_RST;
            r_cfg.inv_wave  <= INV_WAVE_RST;
            r_cfg.twin_trap <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_FOCAL_X:   r_cfg.focal_x   <= pwdata[23:0];
                REG_FOCAL_Y:   r_cfg.focal_y   <= pwdata[23:0];
                REG_FOCAL_Z:   r_cfg.focal_z   <= pwdata[23:0];
                REG_INV_WAVE:  r_cfg.inv_wave  <= pwdata[23:0];
                REG_TWIN_TRAP: r_cfg.twin_trap <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Return the addressed register, unused addresses read zero
    always_comb begin
        unique case (w_idx)
            REG_FOCAL_X:   prdata = {8'd0, r_cfg.focal_x};
            REG_FOCAL_Y:   prdata = {8'd0, r_cfg.focal_y};
            REG_FOCAL_Z:   prdata = {8'd0, r_cfg.focal_z};
            REG_INV_WAVE:  prdata = {8'd0, r_cfg.inv_wave};
            REG_TWIN_TRAP: prdata = {31'd0, r_cfg.twin_trap};
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/pafp_front.sv */
// Front end: takes a position beat, forms offsets to the focal point and the half-turn flag.
`timescale 1ns / 1ps
`default_nettype none

module pafp_front (
    input  wire logic               i_push,
    input  wire logic               i_q_full,
    input  wire pafp_pkg::t_cfg     i_cfg,
    input  wire logic signed [23:0] i_pos_x,
    input  wire logic signed [23:0] i_pos_y,
    input  wire logic signed [23:0] i_pos_z,
    input  wire logic               i_last_in,
    output logic                    o_q_wr,
    output pafp_pkg::t_job          o_job
);
    import pafp_pkg::*;

    // Accept a beat whenever the queue has room
    assign o_q_wr = i_push & ~i_q_full;

    // Offsets to the focal point, one bit wider than the operands
    always_comb begin
        o_job.dx   = {i_pos_x[23], i_pos_x} - {i_cfg.focal_x[23], i_cfg.focal_x};
        o_job.dy   = {i_pos_y[23], i_pos_y} - {i_cfg.focal_y[23], i_cfg.focal_y};
        o_job.dz   = {i_pos_z[23], i_pos_z} - {i_cfg.focal_z[23], i_cfg.focal_z};
        // Half turn only for strictly positive x
        o_job.half = i_cfg.twin_trap & ~i_pos_x[23] & (i_pos_x != 24'sd0);
        o_job.last = i_last_in;
    end

endmodule

`default_nettype wire

/* rtl/pafp_queue.sv */
// Short queue of classified items between the front end and the arithmetic pipeline.
`timescale 1ns / 1ps
`default_nettype none

module pafp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire pafp_pkg::t_job i_data,
    output logic                o_full,
    input  wire logic           i_rd,
    output pafp_pkg::t_job      o_data,
    output logic                o_empty
);
    import pafp_pkg::*;

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wp;
    logic [QUEUE_PTR_W-1:0] r_rp;
    logic [QUEUE_CNT_W-1:0] r_cnt;
    logic                   w_rd;

    assign o_full  = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_rd    = i_rd & ~o_empty;

    // Store the incoming entry
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + QUEUE_PTR_W'(1);
            end
            if (w_rd) begin
                r_rp <= r_rp + QUEUE_PTR_W'(1);
            end
            unique case ({i_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + QUEUE_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QUEUE_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/pafp_back.sv */
// Back end: squares, sum, pipelined square root, scaling to phase and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module pafp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pafp_pkg::t_cfg i_cfg,
    input  wire pafp_pkg::t_job i_job,
    input  wire logic           i_job_valid,
    output logic                o_job_pop,
    input  wire logic           i_pop,
    output logic                o_empty,
    output logic [15:0]         o_phase_turns,
    output logic                o_last_out
);
    import pafp_pkg::*;

    logic w_adv;
    logic w_ofull;

    // Square stage
    logic              r_v_sq;
    logic [SQ_W-1:0]   r_sq_x;
    logic [SQ_W-1:0]   r_sq_y;
    logic [SQ_W-1:0]   r_sq_z;
    logic              r_sq_half;
    logic              r_sq_last;
    logic signed [SUM_W-1:0] w_px;
    logic signed [SUM_W-1:0] w_py;
    logic signed [SUM_W-1:0] w_pz;

    // Sum and square-root stages, index 0 holds the sum
    logic     r_sv    [0:SQRT_STEPS];
    t_root_st r_rs    [0:SQRT_STEPS];
    logic     r_shalf [0:SQRT_STEPS];
    logic     r_slast [0:SQRT_STEPS];

    // Multiply stage
    logic              r_v_mul;
    logic [PROD_W-1:0] r_prod;
    logic              r_m_half;
    logic              r_m_last;
    logic [PROD_W-1:0] w_prod;
    logic [FRAC_W-1:0] w_neg;
    logic [15:0]       w_phase;

    // Result queue
    logic [15:0]          r_o_phase [OUT_DEPTH];
    logic                 r_o_last  [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_owp;
    logic [OUT_PTR_W-1:0] r_orp;
    logic [OUT_CNT_W-1:0] r_ocnt;
    logic                 w_owr;
    logic                 w_ord;

    // Hold the whole pipeline only when a finished result has nowhere to go
    assign w_ofull   = (r_ocnt == OUT_CNT_W'(OUT_DEPTH));
    assign w_adv     = ~(r_v_mul & w_ofull);
    assign o_job_pop = w_adv & i_job_valid;

    assign w_px = i_job.dx * i_job.dx;
    assign w_py = i_job.dy * i_job.dy;
    assign w_pz = i_job.dz * i_job.dz;

    // Square the three offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sq <= 1'b0;
        end else if (w_adv) begin
            r_v_sq <= i_job_valid;
        end
        if (w_adv) begin
            r_sq_x    <= w_px[SQ_W-1:0];
            r_sq_y    <= w_py[SQ_W-1:0];
            r_sq_z    <= w_pz[SQ_W-1:0];
            r_sq_half <= i_job.half;
            r_sq_last <= i_job.last;
        end
    end

    // Add the squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (w_adv) begin
            r_sv[0] <= r_v_sq;
        end
        if (w_adv) begin
            r_rs[0].rem  <= SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);
            r_rs[0].root <= '0;
            r_shalf[0]   <= r_sq_half;
            r_slast[0]   <= r_sq_last;
        end
    end

    // One root bit per stage, highest bit first
    for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_root
        localparam logic [ROOT_W-1:0] BITV = ROOT_W'(1) << (2 * (SQRT_STEPS - k));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k] <= 1'b0;
            end else if (w_adv) begin
                r_sv[k] <= r_sv[k-1];
            end
            if (w_adv) begin
                r_rs[k]    <= root_step(r_rs[k-1], BITV);
                r_shalf[k] <= r_shalf[k-1];
                r_slast[k] <= r_slast[k-1];
            end
        end
    end

    // Scale the distance by the inverse wavelength
    assign w_prod = r_rs[SQRT_STEPS].root[DIST_W-1:0] * i_cfg.inv_wave;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mul <= 1'b0;
        end else if (w_adv) begin
            r_v_mul <= r_sv[SQRT_STEPS];
        end
        if (w_adv) begin
            r_prod   <= w_prod;
            r_m_half <= r_shalf[SQRT_STEPS];
            r_m_last <= r_slast[SQRT_STEPS];
        end
    end

    // Negate, drop the fraction below 2^-16 turn and add any half turn
    assign w_neg   = FRAC_W'(0) - r_prod[FRAC_W-1:0];
    assign w_phase = w_neg[FRAC_W-1:FRAC_W-16] ^ (r_m_half ? HALF_TURN : 16'h0000);

    assign w_owr         = w_adv & r_v_mul;
    assign w_ord         = i_pop & ~o_empty;
    assign o_empty       = (r_ocnt == '0);
    assign o_phase_turns = r_o_phase[r_orp];
    assign o_last_out    = r_o_last[r_orp];

    // Store finished results
    always_ff @(posedge i_clk) begin
        if (w_owr) begin
            r_o_phase[r_owp] <= w_phase;
            r_o_last[r_owp]  <= r_m_last;
        end
    end

    // Result queue pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (w_owr) begin
                r_owp <= r_owp + OUT_PTR_W'(1);
            end
            if (w_ord) begin
                r_orp <= r_orp + OUT_PTR_W'(1);
            end
            unique case ({w_owr, w_ord})
                2'b10:   r_ocnt <= r_ocnt + OUT_CNT_W'(1);
                2'b01:   r_ocnt <= r_ocnt - OUT_CNT_W'(1);
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    // Result queue never overfills
    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= OUT_CNT_W'(OUT_DEPTH))
        else $error("result queue overfilled");

    // A stalled result stays put until it can be stored
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> (r_v_mul && $stable(r_prod) && $stable(r_m_last)))
        else $error("stalled result lost");

    // Final root fits the distance width
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv[SQRT_STEPS] |-> (r_rs[SQRT_STEPS].root[ROOT_W-1:DIST_W] == '0))
        else $error("square root out of range");

endmodule

`default_nettype wire

/* rtl/phased_array_focus_phase.sv */
// Top level of the focal-point phase generator for a phased transducer array.
// Throughput: one beat per cycle while the result queue can take the finished result;
// the square root is a 26-stage pipeline, one root bit a stage.
// A four-entry queue sits between front end and pipeline, another four-entry queue at the output.
// Reset is synchronous, active low: queues empty, registers to focal (0, 0, 31457),
// inverse wavelength 7640000, twin trap off.
`timescale 1ns / 1ps
`default_nettype none

module phased_array_focus_phase (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pafp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [pafp_pkg::PDATA_W-1:0] pwdata,
    output logic      [pafp_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    // Input side
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [23:0]           i_pos_x,
    input  wire logic signed [23:0]           i_pos_y,
    input  wire logic signed [23:0]           i_pos_z,
    input  wire logic                         i_last_in,
    // Result side
    input  wire logic                         pop,
    output logic                              empty,
    output logic [15:0]                       o_phase_turns,
    output logic                              o_full_amplitude,
    output logic                              o_last_out
);
    import pafp_pkg::*;

    t_cfg w_cfg;
    t_job w_job_in;
    t_job w_job_out;
    logic w_q_wr;
    logic w_q_empty;
    logic w_q_rd;

    // Amplitude is always full scale
    assign o_full_amplitude = 1'b1;

    pafp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pafp_front u_front (
        .i_push    (push),
        .i_q_full  (full),
        .i_cfg     (w_cfg),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_pos_z   (i_pos_z),
        .i_last_in (i_last_in),
        .o_q_wr    (w_q_wr),
        .o_job     (w_job_in)
    );

    pafp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_data  (w_job_in),
        .o_full  (full),
        .i_rd    (w_q_rd),
        .o_data  (w_job_out),
        .o_empty (w_q_empty)
    );

    pafp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_job         (w_job_out),
        .i_job_valid   (~w_q_empty),
        .o_job_pop     (w_q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_phase_turns (o_phase_turns),
        .o_last_out    (o_last_out)
    );

endmodule

`default_nettype wire
